FILE: design/swct_pkg.sv
// Package with the shared types and constants of the stopwatch and countdown timer block.
package swct_pkg;

    typedef enum logic [1:0] {
        MODE_WATCH     = 2'd0,
        MODE_SW        = 2'd1,
        MODE_COUNTDOWN = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_UP     = 3'd1,
        KIND_DOWN   = 3'd2,
        KIND_SELECT = 3'd3,
        KIND_CHAR   = 3'd4,
        KIND_LONG   = 3'd5,
        KIND_BACK   = 3'd6
    } kind_t;

    localparam logic [7:0] CHAR_RESET_LO = 8'h72;
    localparam logic [7:0] CHAR_RESET_UP = 8'h52;
    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_EQUAL    = 8'h3D;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;

    // Stopwatch digit limits and the last time before the 32-bit millisecond count wraps.
    localparam logic [3:0]  SW_MS_LAST  = 4'd9;
    localparam logic [6:0]  SW_CS_LAST  = 7'd99;
    localparam logic [5:0]  SW_SEC_LAST = 6'd59;
    localparam logic [5:0]  SW_MIN_LAST = 6'd59;
    localparam logic [10:0] SW_WRAP_HR  = 11'd1193;
    localparam logic [5:0]  SW_WRAP_MIN = 6'd2;
    localparam logic [5:0]  SW_WRAP_SEC = 6'd47;
    localparam logic [6:0]  SW_WRAP_CS  = 7'd29;
    localparam logic [3:0]  SW_WRAP_MS  = 4'd5;

    // Timer set value is kept as minutes and seconds; 65535 s is 1092 min 15 s.
    localparam logic [10:0] TM_RESET_MIN = 11'd5;
    localparam logic [5:0]  TM_RESET_SEC = 6'd0;
    localparam logic [10:0] TM_MAX_MIN   = 11'd1092;
    localparam logic [5:0]  TM_MAX_SEC   = 6'd15;
    localparam logic [5:0]  TM_SEC_LAST  = 6'd59;
    localparam logic [9:0]  TM_MS_LAST   = 10'd999;

    localparam int TDATA_OUT_W = 56;

    typedef struct packed {
        logic tick;
        logic toggle;
        logic clear;
    } sw_cmd_t;

    typedef struct packed {
        logic [10:0] hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [6:0]  centis;
        logic        active;
    } sw_out_t;

    typedef struct packed {
        logic tick;
        logic add10;
        logic sub10;
        logic add60;
        logic sub60;
        logic select;
        logic cancel;
        logic leave;
    } tm_cmd_t;

    typedef struct packed {
        logic run;
        logic editing;
    } tm_stat_t;

    typedef struct packed {
        logic [10:0] minutes;
        logic [5:0]  secs;
        logic        active;
        logic        edit;
        logic        beep;
    } tm_out_t;

endpackage

FILE: design/swct_stopwatch.sv
// Stopwatch kept as running h:m:s.cs digits with a millisecond digit below them.
module swct_stopwatch (
    input  logic              aclk,
    input  logic              aresetn,
    input  swct_pkg::sw_cmd_t cmd,
    output logic              run,
    output swct_pkg::sw_out_t res_next
);

    logic        run_reg, run_next;
    logic [3:0]  ms_reg, ms_next;
    logic [6:0]  cs_reg, cs_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [10:0] hr_reg, hr_next;
    logic        at_wrap;

    always_comb begin
        run_next = run_reg;
        ms_next  = ms_reg;
        cs_next  = cs_reg;
        sec_next = sec_reg;
        min_next = min_reg;
        hr_next  = hr_reg;
        at_wrap  = (hr_reg == swct_pkg::SW_WRAP_HR) && (min_reg == swct_pkg::SW_WRAP_MIN) &&
                   (sec_reg == swct_pkg::SW_WRAP_SEC) && (cs_reg == swct_pkg::SW_WRAP_CS) &&
                   (ms_reg == swct_pkg::SW_WRAP_MS);
        if (cmd.tick && run_reg) begin
            if (at_wrap) begin
                ms_next  = '0;
                cs_next  = '0;
                sec_next = '0;
                min_next = '0;
                hr_next  = '0;
            end else if (ms_reg != swct_pkg::SW_MS_LAST) begin
                ms_next = ms_reg + 4'd1;
            end else begin
                ms_next = '0;
                if (cs_reg != swct_pkg::SW_CS_LAST) begin
                    cs_next = cs_reg + 7'd1;
                end else begin
                    cs_next = '0;
                    if (sec_reg != swct_pkg::SW_SEC_LAST) begin
                        sec_next = sec_reg + 6'd1;
                    end else begin
                        sec_next = '0;
                        if (min_reg != swct_pkg::SW_MIN_LAST) begin
                            min_next = min_reg + 6'd1;
                        end else begin
                            min_next = '0;
                            hr_next  = hr_reg + 11'd1;
                        end
                    end
                end
            end
        end
        if (cmd.toggle) begin
            run_next = !run_reg;
        end
        if (cmd.clear) begin
            ms_next  = '0;
            cs_next  = '0;
            sec_next = '0;
            min_next = '0;
            hr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            ms_reg  <= '0;
            cs_reg  <= '0;
            sec_reg <= '0;
            min_reg <= '0;
            hr_reg  <= '0;
        end else begin
            run_reg <= run_next;
            ms_reg  <= ms_next;
            cs_reg  <= cs_next;
            sec_reg <= sec_next;
            min_reg <= min_next;
            hr_reg  <= hr_next;
        end
    end

    assign run              = run_reg;
    assign res_next.hours   = hr_next;
    assign res_next.minutes = min_next;
    assign res_next.seconds = sec_next;
    assign res_next.centis  = cs_next;
    assign res_next.active  = run_next;

endmodule

FILE: design/swct_timer.sv
// Countdown timer with its set value, edit flag and remaining time as min:sec plus milliseconds.
module swct_timer (
    input  logic               aclk,
    input  logic               aresetn,
    input  swct_pkg::tm_cmd_t  cmd,
    output swct_pkg::tm_stat_t stat,
    output swct_pkg::tm_out_t  res_next
);

    logic [10:0] set_min_reg, set_min_next;
    logic [5:0]  set_sec_reg, set_sec_next;
    logic        run_reg, run_next;
    logic        edit_reg, edit_next;
    logic [10:0] cd_min_reg, cd_min_next;
    logic [5:0]  cd_sec_reg, cd_sec_next;
    logic [9:0]  cd_ms_reg, cd_ms_next;
    logic        beep;

    always_comb begin
        logic [6:0]  add_sec;
        logic [11:0] add_min;
        logic        expire;
        set_min_next = set_min_reg;
        set_sec_next = set_sec_reg;
        run_next     = run_reg;
        edit_next    = edit_reg;
        cd_min_next  = cd_min_reg;
        cd_sec_next  = cd_sec_reg;
        cd_ms_next   = cd_ms_reg;
        beep         = 1'b0;
        add_sec = {1'b0, set_sec_reg} + (cmd.add10 ? 7'd10 : 7'd0);
        add_min = {1'b0, set_min_reg} + (cmd.add60 ? 12'd1 : 12'd0);
        if (add_sec >= 7'd60) begin
            add_sec = add_sec - 7'd60;
            add_min = add_min + 12'd1;
        end
        expire = (cd_min_reg == '0) && (cd_sec_reg == 6'd1) && (cd_ms_reg == 10'd1);

        if (cmd.add10 || cmd.add60) begin
            if ((add_min > {1'b0, swct_pkg::TM_MAX_MIN}) ||
                ((add_min == {1'b0, swct_pkg::TM_MAX_MIN}) &&
                 (add_sec > {1'b0, swct_pkg::TM_MAX_SEC}))) begin
                set_min_next = swct_pkg::TM_MAX_MIN;
                set_sec_next = swct_pkg::TM_MAX_SEC;
            end else begin
                set_min_next = add_min[10:0];
                set_sec_next = add_sec[5:0];
            end
        end
        if (cmd.sub10 && ((set_min_reg != '0) || (set_sec_reg >= 6'd20))) begin
            if (set_sec_reg >= 6'd10) begin
                set_sec_next = set_sec_reg - 6'd10;
            end else begin
                set_sec_next = set_sec_reg + 6'd50;
                set_min_next = set_min_reg - 11'd1;
            end
        end
        if (cmd.sub60 && (set_min_reg != '0)) begin
            set_min_next = set_min_reg - 11'd1;
        end
        if (cmd.select) begin
            if (run_reg) begin
                run_next = 1'b0;
            end else if (edit_reg) begin
                edit_next = 1'b0;
                if ((set_min_reg != '0) || (set_sec_reg != '0)) begin
                    run_next   = 1'b1;
                    cd_ms_next = '0;
                    if (set_sec_reg == swct_pkg::TM_SEC_LAST) begin
                        cd_sec_next = '0;
                        cd_min_next = set_min_reg + 11'd1;
                    end else begin
                        cd_sec_next = set_sec_reg + 6'd1;
                        cd_min_next = set_min_reg;
                    end
                end
            end else begin
                edit_next = 1'b1;
            end
        end
        if (cmd.cancel) begin
            run_next = 1'b0;
        end
        if (cmd.tick && run_reg) begin
            if (expire) begin
                run_next = 1'b0;
                beep     = 1'b1;
            end else if (cd_ms_reg != '0) begin
                cd_ms_next = cd_ms_reg - 10'd1;
            end else begin
                cd_ms_next = swct_pkg::TM_MS_LAST;
                if (cd_sec_reg != '0) begin
                    cd_sec_next = cd_sec_reg - 6'd1;
                end else begin
                    cd_sec_next = swct_pkg::TM_SEC_LAST;
                    cd_min_next = cd_min_reg - 11'd1;
                end
            end
        end
        if (cmd.leave) begin
            edit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_min_reg <= swct_pkg::TM_RESET_MIN;
            set_sec_reg <= swct_pkg::TM_RESET_SEC;
            run_reg     <= 1'b0;
            edit_reg    <= 1'b0;
        end else begin
            set_min_reg <= set_min_next;
            set_sec_reg <= set_sec_next;
            run_reg     <= run_next;
            edit_reg    <= edit_next;
        end
    end

    always_ff @(posedge aclk) begin
        cd_min_reg <= cd_min_next;
        cd_sec_reg <= cd_sec_next;
        cd_ms_reg  <= cd_ms_next;
    end

    assign stat.run         = run_reg;
    assign stat.editing     = edit_reg;
    assign res_next.minutes = run_next ? cd_min_next : set_min_next;
    assign res_next.secs    = run_next ? cd_sec_next : set_sec_next;
    assign res_next.active  = run_next;
    assign res_next.edit    = edit_next;
    assign res_next.beep    = beep;

endmodule

FILE: design/stopwatch_countdown_timer.sv
// Top level of the three-mode watch block: event decode, mode register and result register.
//
// Each input item is one event: s_tuser carries the kind (tick of 1 ms, up, down,
// select, char, long select, back) and s_tdata the character code for char events.
// Every accepted item yields exactly one result item on the m_ side, showing the
// mode, the stopwatch time as h:m:s.cs, the timer's remaining or set time as
// minutes and seconds, the run and edit flags, and the beep and leave pulses.
// The state is updated in the cycle the item is accepted and the result is held
// in an output register, valid from the cycle after acceptance; one item is
// taken every cycle while the receiver does not stall. Stopwatch and countdown
// time are kept as running digit counters, so no division sits in any path.
// s_tready is high whenever the output register is empty or being emptied in the
// same cycle; a stalled receiver holds the result and stops input after one item.
// After reset the mode is clock, the stopwatch is stopped at zero, the timer set
// value is five minutes, and no result is pending.
module stopwatch_countdown_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_char[7:0]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // mode[1:0], sw_hours[12:2], sw_minutes[18:13], sw_seconds[24:19],
    // sw_centis[31:25], timer_minutes[42:32], timer_secs[48:43], sw_active[49],
    // timer_active[50], timer_edit[51], beep[52], leave[53], zero[55:54]
    output logic [55:0] m_tdata
);

    logic                          s_accept;
    swct_pkg::mode_t               mode_reg, mode_next;
    swct_pkg::sw_cmd_t             sw_cmd;
    swct_pkg::tm_cmd_t             tm_cmd;
    swct_pkg::tm_stat_t            tm_stat;
    swct_pkg::sw_out_t             sw_res;
    swct_pkg::tm_out_t             tm_res;
    logic                          sw_run;
    logic                          leave;
    logic                          m_tvalid_reg;
    logic [swct_pkg::TDATA_OUT_W-1:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        logic in_timer;
        logic editing;
        mode_next = mode_reg;
        sw_cmd    = '0;
        tm_cmd    = '0;
        leave     = 1'b0;
        in_timer  = (mode_reg == swct_pkg::MODE_COUNTDOWN);
        editing   = in_timer && tm_stat.editing;
        if (s_accept) begin
            case (s_tuser)
                swct_pkg::KIND_TICK: begin
                    sw_cmd.tick = 1'b1;
                    tm_cmd.tick = 1'b1;
                end
                swct_pkg::KIND_UP: begin
                    if (editing) begin
                        tm_cmd.add10 = 1'b1;
                    end else begin
                        case (mode_reg)
                            swct_pkg::MODE_WATCH:     mode_next = swct_pkg::MODE_COUNTDOWN;
                            swct_pkg::MODE_SW:        mode_next = swct_pkg::MODE_WATCH;
                            swct_pkg::MODE_COUNTDOWN: mode_next = swct_pkg::MODE_SW;
                            default:                  mode_next = mode_reg;
                        endcase
                    end
                end
                swct_pkg::KIND_DOWN: begin
                    if (editing) begin
                        tm_cmd.sub10 = 1'b1;
                    end else begin
                        case (mode_reg)
                            swct_pkg::MODE_WATCH:     mode_next = swct_pkg::MODE_SW;
                            swct_pkg::MODE_SW:        mode_next = swct_pkg::MODE_COUNTDOWN;
                            swct_pkg::MODE_COUNTDOWN: mode_next = swct_pkg::MODE_WATCH;
                            default:                  mode_next = mode_reg;
                        endcase
                    end
                end
                swct_pkg::KIND_SELECT: begin
                    if (mode_reg == swct_pkg::MODE_SW) begin
                        sw_cmd.toggle = 1'b1;
                    end else if (in_timer) begin
                        tm_cmd.select = 1'b1;
                    end
                end
                swct_pkg::KIND_CHAR: begin
                    if ((mode_reg == swct_pkg::MODE_SW) && !sw_run &&
                        ((s_tdata == swct_pkg::CHAR_RESET_LO) ||
                         (s_tdata == swct_pkg::CHAR_RESET_UP))) begin
                        sw_cmd.clear = 1'b1;
                    end else if (editing) begin
                        if ((s_tdata == swct_pkg::CHAR_PLUS) ||
                            (s_tdata == swct_pkg::CHAR_EQUAL)) begin
                            tm_cmd.add60 = 1'b1;
                        end else if (s_tdata == swct_pkg::CHAR_MINUS) begin
                            tm_cmd.sub60 = 1'b1;
                        end
                    end
                end
                swct_pkg::KIND_LONG: begin
                    if (in_timer && tm_stat.run) begin
                        tm_cmd.cancel = 1'b1;
                    end else begin
                        leave = 1'b1;
                    end
                end
                swct_pkg::KIND_BACK: begin
                    leave = 1'b1;
                end
                default: begin
                end
            endcase
        end
        tm_cmd.leave = leave;
    end

    swct_stopwatch u_sw (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (sw_cmd),
        .run      (sw_run),
        .res_next (sw_res)
    );

    swct_timer u_tm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (tm_cmd),
        .stat     (tm_stat),
        .res_next (tm_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= swct_pkg::MODE_WATCH;
            m_tvalid_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {2'b00, leave, tm_res.beep, tm_res.edit, tm_res.active,
                            sw_res.active, tm_res.secs, tm_res.minutes, sw_res.centis,
                            sw_res.seconds, sw_res.minutes, sw_res.hours, mode_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/swct_checker.sv
// Port-level checker for the watch block and its bind to the top level.
module swct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Stalled result item changed or dropped.");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("Accepted item produced no result item.");

    a_beep_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[52]) |-> (!m_tdata[50] && !m_tdata[53]))
        else $error("Beep with the countdown still running or with leave.");

    a_leave_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[53]) |-> !m_tdata[51])
        else $error("Leave item still shows the timer in edit.");

    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[18:13] < 6'd60) && (m_tdata[24:19] < 6'd60) &&
                      (m_tdata[31:25] < 7'd100) && (m_tdata[48:43] < 6'd60)))
        else $error("Time digit out of range.");

endmodule

bind stopwatch_countdown_timer swct_checker u_swct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/stopwatch_countdown_timer_test.sv
// Self-checking testbench for the stopwatch and countdown timer block.
module stopwatch_countdown_timer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int LONG_HOLD = 60;

    typedef struct packed {
        logic [1:0]  pad;
        logic        leave;
        logic        beep;
        logic        timer_edit;
        logic        timer_active;
        logic        sw_active;
        logic [5:0]  timer_secs;
        logic [10:0] timer_minutes;
        logic [6:0]  sw_centis;
        logic [5:0]  sw_seconds;
        logic [5:0]  sw_minutes;
        logic [10:0] sw_hours;
        logic [1:0]  mode;
    } readout_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [2:0]  s_tuser = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    readout_t    pending_readouts[$];
    int          error_count = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;

    // Predicted watch state.
    logic [31:0]     ms_now;
    logic [31:0]     sw_begin;
    logic [31:0]     sw_total;
    logic [31:0]     tm_end;
    logic [15:0]     tm_set;
    swct_pkg::mode_t mode_q;
    logic            sw_on;
    logic            tm_on;
    logic            tm_edit;

    stopwatch_countdown_timer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic reset_watch();
        ms_now   = '0;
        sw_begin = '0;
        sw_total = '0;
        tm_end   = '0;
        tm_set   = 16'd300;
        mode_q   = swct_pkg::MODE_WATCH;
        sw_on    = 1'b0;
        tm_on    = 1'b0;
        tm_edit  = 1'b0;
    endtask

    function automatic logic [15:0] sat_add(logic [15:0] value, logic [31:0] amount);
        logic [31:0] sum;
        sum = {16'h0000, value} + amount;
        return (sum > 32'd65535) ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic readout_t advance_watch(logic [2:0] kind, logic [7:0] ch);
        logic        beep;
        logic        leave;
        logic        in_timer;
        logic [31:0] diff;
        logic [31:0] el;
        logic [31:0] remain;
        readout_t    r;
        beep = 1'b0;
        leave = 1'b0;
        in_timer = (mode_q == swct_pkg::MODE_COUNTDOWN);
        case (kind)
            swct_pkg::KIND_TICK: begin
                ms_now = ms_now + 32'd1;
                diff = ms_now - tm_end;
                if (tm_on && !diff[31]) begin
                    tm_on = 1'b0;
                    tm_end = '0;
                    beep = 1'b1;
                end
            end
            swct_pkg::KIND_UP: begin
                if (in_timer && tm_edit) tm_set = sat_add(tm_set, 32'd10);
                else mode_q = swct_pkg::mode_t'((int'(mode_q) + 2) % 3);
            end
            swct_pkg::KIND_DOWN: begin
                if (in_timer && tm_edit) begin
                    if (tm_set >= 16'd20) tm_set = tm_set - 16'd10;
                end else begin
                    mode_q = swct_pkg::mode_t'((int'(mode_q) + 1) % 3);
                end
            end
            swct_pkg::KIND_SELECT: begin
                if (mode_q == swct_pkg::MODE_SW) begin
                    if (sw_on) begin
                        sw_total = sw_total + (ms_now - sw_begin);
                        sw_on = 1'b0;
                    end else begin
                        sw_begin = ms_now;
                        sw_on = 1'b1;
                    end
                end else if (in_timer) begin
                    if (tm_on) begin
                        tm_on = 1'b0;
                        tm_end = '0;
                    end else if (tm_edit) begin
                        tm_edit = 1'b0;
                        if (tm_set != 16'd0) begin
                            tm_end = ms_now + 32'(tm_set) * 32'd1000;
                            tm_on = 1'b1;
                        end
                    end else begin
                        tm_edit = 1'b1;
                    end
                end
            end
            swct_pkg::KIND_CHAR: begin
                if (mode_q == swct_pkg::MODE_SW &&
                    (ch == swct_pkg::CHAR_RESET_LO || ch == swct_pkg::CHAR_RESET_UP) &&
                    !sw_on) begin
                    sw_total = '0;
                end else if (in_timer && tm_edit) begin
                    if (ch == swct_pkg::CHAR_PLUS || ch == swct_pkg::CHAR_EQUAL)
                        tm_set = sat_add(tm_set, 32'd60);
                    else if (ch == swct_pkg::CHAR_MINUS && tm_set >= 16'd60)
                        tm_set = tm_set - 16'd60;
                end
            end
            swct_pkg::KIND_LONG: begin
                if (in_timer && tm_on) begin
                    tm_on = 1'b0;
                    tm_end = '0;
                end else begin
                    leave = 1'b1;
                end
            end
            swct_pkg::KIND_BACK: leave = 1'b1;
            default: ;
        endcase
        if (leave) tm_edit = 1'b0;

        el = sw_total + (sw_on ? (ms_now - sw_begin) : 32'd0);
        remain = tm_on ? ((tm_end - ms_now) / 32'd1000) + 32'd1 : {16'h0000, tm_set};
        r = '0;
        r.mode          = mode_q;
        r.sw_hours      = 11'(el / 32'd3600000);
        r.sw_minutes    = 6'((el / 32'd60000) % 32'd60);
        r.sw_seconds    = 6'((el / 32'd1000) % 32'd60);
        r.sw_centis     = 7'((el / 32'd10) % 32'd100);
        r.timer_minutes = 11'(remain / 32'd60);
        r.timer_secs    = 6'(remain % 32'd60);
        r.sw_active     = sw_on;
        r.timer_active  = tm_on;
        r.timer_edit    = tm_edit;
        r.beep          = beep;
        r.leave         = leave;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        readout_t got;
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readouts.size() == 0) begin
                report_mismatch("result item with no item expected");
            end else begin
                got = readout_t'(m_tdata);
                want = pending_readouts.pop_front();
                check_field("mode", got.mode, want.mode);
                check_field("sw_hours", got.sw_hours, want.sw_hours);
                check_field("sw_minutes", got.sw_minutes, want.sw_minutes);
                check_field("sw_seconds", got.sw_seconds, want.sw_seconds);
                check_field("sw_centis", got.sw_centis, want.sw_centis);
                check_field("timer_minutes", got.timer_minutes, want.timer_minutes);
                check_field("timer_secs", got.timer_secs, want.timer_secs);
                check_field("sw_active", got.sw_active, want.sw_active);
                check_field("timer_active", got.timer_active, want.timer_active);
                check_field("timer_edit", got.timer_edit, want.timer_edit);
                check_field("beep", got.beep, want.beep);
                check_field("leave", got.leave, want.leave);
                check_field("pad", got.pad, want.pad);
            end
        end
    end

    initial begin : drain
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_event(logic [2:0] kind, logic [7:0] ch);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        pending_readouts.push_back(advance_watch(kind, ch));
        items_sent++;
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_event(swct_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0: return swct_pkg::CHAR_RESET_LO;
            1: return swct_pkg::CHAR_RESET_UP;
            2: return swct_pkg::CHAR_PLUS;
            3: return swct_pkg::CHAR_EQUAL;
            4: return swct_pkg::CHAR_MINUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic goto_mode(swct_pkg::mode_t target);
        if (tm_edit) send_event(swct_pkg::KIND_BACK, 8'h00);
        while (mode_q != target) send_event(swct_pkg::KIND_DOWN, 8'h00);
    endtask

    task automatic enter_timer_edit();
        goto_mode(swct_pkg::MODE_COUNTDOWN);
        if (tm_on) send_event(swct_pkg::KIND_LONG, 8'h00);
        if (!tm_edit) send_event(swct_pkg::KIND_SELECT, 8'h00);
    endtask

    task automatic test_basics();
        send_event(swct_pkg::KIND_TICK, 8'hFF);
        send_event(KIND_UNUSED, 8'hFF);
        send_event(swct_pkg::KIND_CHAR, 8'h00);
        send_event(swct_pkg::KIND_BACK, 8'h00);
        send_event(swct_pkg::KIND_LONG, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_ticks(12);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_RESET_LO);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_RESET_UP);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_TICK, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_RESET_LO);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_UP, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_UP, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_PLUS);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_EQUAL);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_MINUS);
        send_event(swct_pkg::KIND_CHAR, 8'hFF);
        send_event(swct_pkg::KIND_BACK, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_TICK, 8'h00);
        send_event(swct_pkg::KIND_LONG, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
    endtask

    task automatic test_zero_set();
        enter_timer_edit();
        while (tm_set >= 16'd60) send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_MINUS);
        while (tm_set != 16'd60) send_event(swct_pkg::KIND_UP, 8'h00);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_MINUS);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_MINUS);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_ticks(3);
    endtask

    task automatic test_countdown();
        enter_timer_edit();
        while (tm_set >= 16'd60) send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_MINUS);
        while (tm_set >= 16'd20) send_event(swct_pkg::KIND_DOWN, 8'h00);
        if (tm_set == 16'd0) send_event(swct_pkg::KIND_UP, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_ticks(40);
        goto_mode(swct_pkg::MODE_COUNTDOWN);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
    endtask

    task automatic test_set_raise();
        enter_timer_edit();
        repeat (8) send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_PLUS);
        send_event(swct_pkg::KIND_CHAR, swct_pkg::CHAR_EQUAL);
        send_event(swct_pkg::KIND_UP, 8'h00);
        send_event(swct_pkg::KIND_DOWN, 8'h00);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
        send_ticks(5);
        send_event(swct_pkg::KIND_SELECT, 8'h00);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_ticks(40);
    endtask

    task automatic test_random(int count);
        int last;
        last = items_sent + count;
        while (items_sent < last) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    goto_mode(swct_pkg::MODE_SW);
                    send_event(swct_pkg::KIND_SELECT, 8'($urandom_range(0, 255)));
                    send_ticks($urandom_range(1, 300));
                    if ($urandom_range(0, 1)) send_event(swct_pkg::KIND_CHAR, pick_char());
                    send_event(swct_pkg::KIND_SELECT, 8'h00);
                    if ($urandom_range(0, 1)) send_event(swct_pkg::KIND_CHAR, pick_char());
                end
                3, 4, 5: begin
                    enter_timer_edit();
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 3))
                            0: send_event(swct_pkg::KIND_UP, 8'($urandom_range(0, 255)));
                            1: send_event(swct_pkg::KIND_DOWN, 8'($urandom_range(0, 255)));
                            2: send_event(swct_pkg::KIND_CHAR, pick_char());
                            default: send_event(swct_pkg::KIND_CHAR,
                                                $urandom_range(0, 1) ? swct_pkg::CHAR_PLUS
                                                                     : swct_pkg::CHAR_MINUS);
                        endcase
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        send_event(swct_pkg::KIND_SELECT, 8'h00);
                        send_ticks($urandom_range(1, 400));
                        if ($urandom_range(0, 1))
                            send_event($urandom_range(0, 1) ? swct_pkg::KIND_LONG
                                                            : swct_pkg::KIND_SELECT, 8'h00);
                    end else begin
                        send_event($urandom_range(0, 1) ? swct_pkg::KIND_LONG
                                                        : swct_pkg::KIND_BACK, 8'h00);
                    end
                end
                6, 7: begin
                    repeat ($urandom_range(1, 8))
                        send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
                default: send_ticks($urandom_range(1, 100));
            endcase
        end
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        repeat (100) send_event(3'($urandom_range(0, 7)), pick_char());
    endtask

    initial begin
        reset_watch();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_basics();
        test_zero_set();
        test_countdown();
        test_set_raise();
        test_backpressure();
        test_random(250);
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/swct_pkg.sv
design/swct_stopwatch.sv
design/swct_timer.sv
design/stopwatch_countdown_timer.sv
design/swct_checker.sv
tb/stopwatch_countdown_timer_test.sv
